// ===== hdl/xcptr_pkg.sv =====
// Package for the x86 call pattern target resolver.
// Holds opcode constants, pattern kind codes, config indexes and the result type.
// No dependencies.
`timescale 1ns / 1ps

package xcptr_pkg;

  localparam int unsigned RVA_W     = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEFT_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  typedef enum logic [1:0] {
    KIND_DIRECT   = 2'd0,
    KIND_INDIRECT = 2'd1,
    KIND_PRO64    = 2'd2,
    KIND_PRO32    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PE32_PLUS  = 2'd0,
    CFG_IMAGE_SIZE = 2'd1
  } cfg_idx_t;

  localparam logic [BYTE_W-1:0] OP_CALL_REL  = 8'he8;
  localparam logic [BYTE_W-1:0] OP_GRP5      = 8'hff;
  localparam logic [BYTE_W-1:0] MODRM_CALL   = 8'h15;
  localparam logic [BYTE_W-1:0] PFX_REX_W    = 8'h48;
  localparam logic [BYTE_W-1:0] OP_ALU_IMM8  = 8'h83;
  localparam logic [BYTE_W-1:0] MODRM_SUB_SP = 8'hec;
  localparam logic [BYTE_W-1:0] IMM_FRAME    = 8'h28;
  localparam logic [BYTE_W-1:0] OP_PUSH_BP   = 8'h55;
  localparam logic [BYTE_W-1:0] OP_MOV_RM    = 8'h8b;

  localparam logic [LEFT_W-1:0] LEN_DIRECT   = 3'd5;
  localparam logic [LEFT_W-1:0] LEN_INDIRECT = 3'd6;
  localparam logic [LEFT_W-1:0] LEN_PRO64    = 3'd4;
  localparam logic [LEFT_W-1:0] LEN_PRO32    = 3'd3;

  localparam logic             PE32_PLUS_RST  = 1'b1;
  localparam logic [RVA_W-1:0] IMAGE_SIZE_RST = '0;

  typedef struct packed {
    logic             found;
    kind_t            kind;
    logic [RVA_W-1:0] target;
  } result_t;

endpackage

// ===== hdl/x86_call_pattern_target_resolver.sv =====
// Top level of the x86 call pattern target resolver: input register, pattern
// match and target check, result register. Depends on xcptr_pkg.
//
//   channel | ports                         | handshake
//   in      | in_position_rva..in_bytes_left | in_valid / in_stall
//   out     | out_found, out_pattern_kind,   | out_valid / out_stall
//           | out_target_rva                 |
//   cfg     | cfg_index, cfg_data            | cfg_valid / cfg_ready
//
// One transaction per cycle while out_stall is low.
// The input register feeds one 34-bit add and compare into the result register.
// in_stall rises only when both registers are full and out_stall is high.
// Synchronous active-low reset empties both stages and restores config defaults.
// cfg_ready is always high.
`timescale 1ns / 1ps

module x86_call_pattern_target_resolver (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [xcptr_pkg::RVA_W-1:0]        in_position_rva,
  input  logic [xcptr_pkg::BYTE_W-1:0]       in_byte0,
  input  logic [xcptr_pkg::BYTE_W-1:0]       in_byte1,
  input  logic [xcptr_pkg::BYTE_W-1:0]       in_byte2,
  input  logic [xcptr_pkg::BYTE_W-1:0]       in_byte3,
  input  logic [xcptr_pkg::BYTE_W-1:0]       in_byte4,
  input  logic [xcptr_pkg::BYTE_W-1:0]       in_byte5,
  input  logic [xcptr_pkg::LEFT_W-1:0]       in_bytes_left,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [1:0]                         out_pattern_kind,
  output logic [xcptr_pkg::RVA_W-1:0]        out_target_rva,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [xcptr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [xcptr_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import xcptr_pkg::*;

  logic             pe32_plus_r;
  logic [RVA_W-1:0] image_size_r;

  logic              s1_valid_r;
  logic [RVA_W-1:0]  rva_r;
  logic [BYTE_W-1:0] b0_r, b1_r, b2_r, b3_r, b4_r, b5_r;
  logic [LEFT_W-1:0] left_r;

  logic    s2_valid_r;
  result_t res_r;
  result_t res_nxt;

  logic s2_en;
  logic s1_en;

  logic              is_direct, is_indirect, is_pro64, is_pro32;
  logic [RVA_W-1:0]  disp;
  logic [LEFT_W-1:0] call_len;
  logic [RVA_W+1:0]  sum;
  logic              tgt_ok;

  assign cfg_ready = 1'b1;
  assign s2_en     = !s2_valid_r || !out_stall;
  assign s1_en     = !s1_valid_r || s2_en;
  assign in_stall  = !s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pe32_plus_r  <= PE32_PLUS_RST;
      image_size_r <= IMAGE_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PE32_PLUS:  pe32_plus_r  <= cfg_data[0];
        CFG_IMAGE_SIZE: image_size_r <= cfg_data[RVA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      rva_r  <= in_position_rva;
      b0_r   <= in_byte0;
      b1_r   <= in_byte1;
      b2_r   <= in_byte2;
      b3_r   <= in_byte3;
      b4_r   <= in_byte4;
      b5_r   <= in_byte5;
      left_r <= in_bytes_left;
    end
  end

  always_comb begin
    is_direct   = pe32_plus_r && (left_r >= LEN_DIRECT) && (b0_r == OP_CALL_REL);
    is_indirect = pe32_plus_r && (left_r >= LEN_INDIRECT) &&
                  (b0_r == OP_GRP5) && (b1_r == MODRM_CALL);
    is_pro64    = pe32_plus_r && (left_r >= LEN_PRO64) && (b0_r == PFX_REX_W) &&
                  (b1_r == OP_ALU_IMM8) && (b2_r == MODRM_SUB_SP) && (b3_r == IMM_FRAME);
    is_pro32    = !pe32_plus_r && (left_r >= LEN_PRO32) && (b0_r == OP_PUSH_BP) &&
                  (b1_r == OP_MOV_RM) && (b2_r == MODRM_SUB_SP);

    if (is_direct) begin
      disp     = {b4_r, b3_r, b2_r, b1_r};
      call_len = LEN_DIRECT;
    end else begin
      disp     = {b5_r, b4_r, b3_r, b2_r};
      call_len = LEN_INDIRECT;
    end

    sum    = {2'b00, rva_r} + {{(RVA_W-1){1'b0}}, call_len} + {{2{disp[RVA_W-1]}}, disp};
    tgt_ok = !sum[RVA_W+1] && !sum[RVA_W] &&
             ((image_size_r == '0) || (sum[RVA_W-1:0] < image_size_r));

    res_nxt = '{found: 1'b0, kind: KIND_DIRECT, target: '0};
    if (is_direct || is_indirect) begin
      if (tgt_ok) begin
        res_nxt.found  = 1'b1;
        res_nxt.kind   = is_direct ? KIND_DIRECT : KIND_INDIRECT;
        res_nxt.target = sum[RVA_W-1:0];
      end
    end else if (is_pro64) begin
      res_nxt = '{found: 1'b1, kind: KIND_PRO64, target: rva_r};
    end else if (is_pro32) begin
      res_nxt = '{found: 1'b1, kind: KIND_PRO32, target: rva_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = s2_valid_r;
  assign out_found        = res_r.found;
  assign out_pattern_kind = res_r.kind;
  assign out_target_rva   = res_r.target;

endmodule

// ===== hdl/xcptr_checker.sv =====
// Port-level checker for x86_call_pattern_target_resolver, with its bind.
// Depends on xcptr_pkg.
`timescale 1ns / 1ps

module xcptr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_found,
  input logic [1:0]                  out_pattern_kind,
  input logic [xcptr_pkg::RVA_W-1:0] out_target_rva
);
  import xcptr_pkg::*;

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) &&
      $stable(out_pattern_kind) && $stable(out_target_rva))
    else $error("stalled result changed");

  // drop all results on reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a miss carries zero kind and target
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_pattern_kind == KIND_DIRECT && out_target_rva == '0)
    else $error("miss with nonzero payload");

  // back-pressure only from a stalled full output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule

bind x86_call_pattern_target_resolver xcptr_checker u_xcptr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_found        (out_found),
  .out_pattern_kind (out_pattern_kind),
  .out_target_rva   (out_target_rva)
);

// ===== dv/tb_top.sv =====
// Testbench for x86_call_pattern_target_resolver: directed and random code windows
// under several register settings, each result checked against a built-in predictor.
// Depends on xcptr_pkg and the resolver RTL.
`timescale 1ns / 1ps

module tb_top;
  import xcptr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam longint RVA_SPAN = 64'sh1_0000_0000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [RVA_W-1:0]             rva;
    logic [5:0][BYTE_W-1:0]       code;
    logic [LEFT_W-1:0]            left;
  } window_t;

  class target_scoreboard;
    logic             pe32_plus;
    logic [RVA_W-1:0] image_size;
    result_t          expected_hits[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      misses;
    int unsigned      hits_by_kind[4];
    int unsigned      settings;

    function new();
      pe32_plus = PE32_PLUS_RST;
      image_size = IMAGE_SIZE_RST;
      mismatches = 0;
      checked = 0;
      misses = 0;
      settings = 0;
      foreach (hits_by_kind[k]) hits_by_kind[k] = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
      settings++;
      case (index)
        CFG_PE32_PLUS: pe32_plus = data[0];
        CFG_IMAGE_SIZE: image_size = data;
        default: ;
      endcase
    endfunction

    function result_t resolve_window(window_t w);
      result_t          r;
      logic             is_call;
      logic [LEFT_W-1:0] len;
      logic [31:0]      disp;
      longint           t;
      r = '0;
      is_call = 1'b0;
      len = '0;
      disp = '0;
      if (pe32_plus) begin
        if (w.left >= LEN_DIRECT && w.code[0] == OP_CALL_REL) begin
          is_call = 1'b1;
          len = LEN_DIRECT;
          disp = w.code[4:1];
          r.kind = KIND_DIRECT;
        end else if (w.left >= LEN_INDIRECT && w.code[0] == OP_GRP5 &&
                     w.code[1] == MODRM_CALL) begin
          is_call = 1'b1;
          len = LEN_INDIRECT;
          disp = w.code[5:2];
          r.kind = KIND_INDIRECT;
        end else if (w.left >= LEN_PRO64 && w.code[0] == PFX_REX_W &&
                     w.code[1] == OP_ALU_IMM8 && w.code[2] == MODRM_SUB_SP &&
                     w.code[3] == IMM_FRAME) begin
          r.found = 1'b1;
          r.kind = KIND_PRO64;
          r.target = w.rva;
        end
      end else if (w.left >= LEN_PRO32 && w.code[0] == OP_PUSH_BP &&
                   w.code[1] == OP_MOV_RM && w.code[2] == MODRM_SUB_SP) begin
        r.found = 1'b1;
        r.kind = KIND_PRO32;
        r.target = w.rva;
      end
      if (is_call) begin
        t = longint'(w.rva) + longint'(len) + longint'($signed(disp));
        if (t >= 0 && t < RVA_SPAN && (image_size == 0 || t < longint'(image_size))) begin
          r.found = 1'b1;
          r.target = t[31:0];
        end else begin
          r.kind = KIND_DIRECT;
        end
      end
      return r;
    endfunction

    function void note_window(window_t w);
      expected_hits = {expected_hits, resolve_window(w)};
    endfunction

    function void check_result(logic found, logic [1:0] kind, logic [RVA_W-1:0] target);
      result_t exp;
      if (expected_hits.size() == 0) begin
        $error("result with no window pending: found %0d kind %0d target %h",
               found, kind, target);
        mismatches++;
        return;
      end
      exp = expected_hits.pop_front();
      checked++;
      if (exp.found) hits_by_kind[exp.kind]++;
      else misses++;
      if (exp.found !== found) begin
        $error("found: expected %0d, got %0d", exp.found, found);
        mismatches++;
      end
      if (exp.kind !== kind) begin
        $error("pattern_kind: expected %0d, got %0d", exp.kind, kind);
        mismatches++;
      end
      if (exp.target !== target) begin
        $error("target_rva: expected %h, got %h", exp.target, target);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_hits.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [RVA_W-1:0]      in_position_rva;
  logic [BYTE_W-1:0]     in_byte0, in_byte1, in_byte2, in_byte3, in_byte4, in_byte5;
  logic [LEFT_W-1:0]     in_bytes_left;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_found;
  logic [1:0]            out_pattern_kind;
  logic [RVA_W-1:0]      out_target_rva;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DAT_W-1:0]  cfg_data;

  target_scoreboard sb;
  int unsigned      cycle_count = 0;
  int unsigned      in_idle_max = 11;
  int unsigned      out_idle_max = 11;

  x86_call_pattern_target_resolver DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_position_rva  (in_position_rva),
    .in_byte0         (in_byte0),
    .in_byte1         (in_byte1),
    .in_byte2         (in_byte2),
    .in_byte3         (in_byte3),
    .in_byte4         (in_byte4),
    .in_byte5         (in_byte5),
    .in_bytes_left    (in_bytes_left),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_pattern_kind (out_pattern_kind),
    .out_target_rva   (out_target_rva),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_valid && cfg_ready === 1'b1) sb.write_register(cfg_index, cfg_data);
      if (in_valid && in_stall === 1'b0)
        sb.note_window(window_t'({in_position_rva, in_byte5, in_byte4, in_byte3,
                                  in_byte2, in_byte1, in_byte0, in_bytes_left}));
      if (out_valid === 1'b1 && !out_stall)
        sb.check_result(out_found, out_pattern_kind, out_target_rva);
    end
  end

  // result side: hold stall at random, then take one transaction
  initial begin
    int unsigned hold;
    forever begin
      hold = $urandom_range(0, out_idle_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
    end
  end

  function automatic window_t plain(logic [RVA_W-1:0] rva, logic [47:0] code,
                                    logic [LEFT_W-1:0] left);
    window_t w;
    w.rva = rva;
    w.code = code;
    w.left = left;
    return w;
  endfunction

  function automatic window_t direct_call(logic [RVA_W-1:0] rva, logic [31:0] disp,
                                          logic [LEFT_W-1:0] left);
    return plain(rva, {8'h00, disp, OP_CALL_REL}, left);
  endfunction

  function automatic window_t indirect_call(logic [RVA_W-1:0] rva, logic [31:0] disp,
                                            logic [LEFT_W-1:0] left);
    return plain(rva, {disp, MODRM_CALL, OP_GRP5}, left);
  endfunction

  function automatic window_t random_window();
    window_t     w;
    logic [31:0] span;
    logic [31:0] tgt;
    int unsigned sel;
    int unsigned flip_pos;
    w.rva = $urandom();
    w.code = {16'($urandom()), $urandom()};
    w.left = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd6;
    span = sb.image_size;
    if (span != 0 && $urandom_range(0, 1) == 1) w.rva = $urandom_range(0, span - 1);
    if (span != 0 && $urandom_range(0, 3) != 0) begin
      tgt = ($urandom_range(0, 3) == 0) ? span - $urandom_range(0, 2)
                                        : $urandom_range(0, span);
    end else begin
      tgt = $urandom();
    end
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: begin
        w.code[0] = OP_CALL_REL;
        if ($urandom_range(0, 3) != 0) w.code[4:1] = tgt - w.rva - 32'(LEN_DIRECT);
      end
      2, 3: begin
        w.code[0] = OP_GRP5;
        w.code[1] = MODRM_CALL;
        if ($urandom_range(0, 3) != 0) w.code[5:2] = tgt - w.rva - 32'(LEN_INDIRECT);
      end
      4: w.code[3:0] = {IMM_FRAME, MODRM_SUB_SP, OP_ALU_IMM8, PFX_REX_W};
      5: w.code[2:0] = {MODRM_SUB_SP, OP_MOV_RM, OP_PUSH_BP};
      6: begin
        case ($urandom_range(0, 2))
          0: w.code[3:0] = {IMM_FRAME, MODRM_SUB_SP, OP_ALU_IMM8, PFX_REX_W};
          1: w.code[2:0] = {MODRM_SUB_SP, OP_MOV_RM, OP_PUSH_BP};
          default: w.code[1:0] = {MODRM_CALL, OP_GRP5};
        endcase
        sel = $urandom_range(0, 2);
        flip_pos = $urandom_range(0, 7);
        w.code[sel][flip_pos] = ~w.code[sel][flip_pos];
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_window(window_t w);
    int unsigned gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_position_rva <= w.rva;
    in_byte0        <= w.code[0];
    in_byte1        <= w.code[1];
    in_byte2        <= w.code[2];
    in_byte3        <= w.code[3];
    in_byte4        <= w.code[4];
    in_byte5        <= w.code[5];
    in_bytes_left   <= w.left;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, wait out every pending result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    window_t pro64;
    window_t pro32;
    sb = new();
    pro64 = plain('0, {16'h0, IMM_FRAME, MODRM_SUB_SP, OP_ALU_IMM8, PFX_REX_W}, 3'd4);
    pro32 = plain('0, {24'h0, MODRM_SUB_SP, OP_MOV_RM, OP_PUSH_BP}, 3'd3);
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_position_rva <= '0;
    in_byte0        <= '0;
    in_byte1        <= '0;
    in_byte2        <= '0;
    in_byte3        <= '0;
    in_byte4        <= '0;
    in_byte5        <= '0;
    in_bytes_left   <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_window(direct_call(32'h0, 32'h0, 3'd6));
    send_window(direct_call(32'h0, 32'hFFFF_FFFB, 3'd5));
    send_window(direct_call(32'h0, 32'hFFFF_FFFA, 3'd7));
    send_window(direct_call(32'hFFFF_FFF0, 32'h0000_000A, 3'd6));
    send_window(direct_call(32'hFFFF_FFFF, 32'h7FFF_FFFF, 3'd6));
    send_window(direct_call(32'h0000_1000, 32'h8000_0000, 3'd6));
    send_window(direct_call(32'h1234_5678, 32'h0, 3'd4));
    send_window(indirect_call(32'h0000_1000, 32'h0000_0100, 3'd6));
    send_window(indirect_call(32'h0000_1000, 32'h0000_0100, 3'd5));
    send_window(indirect_call(32'hFFFF_FFF9, 32'h0, 3'd7));
    send_window(indirect_call(32'h0, 32'hFFFF_FFF9, 3'd6));
    send_window(plain(32'hFFFF_FFFF, pro64.code, 3'd4));
    send_window(plain(32'h0, pro64.code, 3'd3));
    send_window(plain(32'h40, pro32.code, 3'd6));
    send_window(plain(32'h0, 48'h0, 3'd0));
    send_window(plain(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'd7));
    drain();

    write_register(CFG_IMAGE_SIZE, 32'h0000_1000);
    send_window(direct_call(32'h0000_0FF0, 32'h0000_000A, 3'd6));
    send_window(direct_call(32'h0000_0FF0, 32'h0000_000B, 3'd6));
    send_window(indirect_call(32'h0000_0FF0, 32'h0000_0009, 3'd6));
    drain();

    write_register(CFG_PE32_PLUS, 32'hFFFF_FFFE);
    write_register(CFG_UNMAPPED, 32'hFFFF_FFFF);
    send_window(plain(32'hFFFF_FFFF, pro32.code, 3'd3));
    send_window(plain(32'h0, pro32.code, 3'd2));
    send_window(plain(32'h10, pro32.code, 3'd7));
    send_window(direct_call(32'h0, 32'h0, 3'd6));
    send_window(plain(32'h0, pro64.code, 3'd6));
    drain();

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          write_register(CFG_PE32_PLUS, 32'h1);
          write_register(CFG_IMAGE_SIZE, 32'h0);
        end
        1: write_register(CFG_IMAGE_SIZE, 32'hFFFF_FFFF);
        2: begin
          write_register(CFG_PE32_PLUS, 32'h0);
          write_register(CFG_IMAGE_SIZE, $urandom());
        end
        3: begin
          write_register(CFG_PE32_PLUS, 32'hFFFF_FFFF);
          write_register(CFG_IMAGE_SIZE, 32'h1);
        end
        4: write_register(CFG_IMAGE_SIZE, $urandom_range(16, 65536));
        5: begin
          write_register(CFG_PE32_PLUS, 32'h0);
          write_register(CFG_IMAGE_SIZE, 32'hFFFF_FFFF);
        end
        default: begin
          write_register(CFG_PE32_PLUS, 32'h1);
          write_register(CFG_IMAGE_SIZE, $urandom());
        end
      endcase
      in_idle_max = (p % 3 == 2) ? 0 : 11;
      out_idle_max = (p % 3 == 2) ? 0 : 11;
      repeat (ITEMS_PER_PHASE) send_window(random_window());
      drain();
    end

    $display("%0d windows checked over %0d register writes", sb.checked, sb.settings);
    $display("hits: direct %0d, indirect %0d, x64 prologue %0d, x86 prologue %0d; misses %0d",
             sb.hits_by_kind[KIND_DIRECT], sb.hits_by_kind[KIND_INDIRECT],
             sb.hits_by_kind[KIND_PRO64], sb.hits_by_kind[KIND_PRO32], sb.misses);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
